FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on i_clk and i_rst_n.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/core/rrts_pkg.sv
package rrts_pkg;

    localparam int THREAD_COUNT    = 6;
    localparam int SEMAPHORE_COUNT = 8;

    localparam int CMD_W = 3;
    localparam int SEM_W = 3;
    localparam int TID_W = 3;
    localparam int BLK_W = 4;
    localparam int VAL_W = 16;

    localparam logic [VAL_W-1:0] VAL_SMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_SMAX = {1'b0, {(VAL_W-1){1'b1}}};

    localparam logic [SEM_W:0]   SEM_LIMIT   = (SEM_W+1)'(SEMAPHORE_COUNT);
    localparam logic [TID_W-1:0] TID_LAST    = TID_W'(THREAD_COUNT - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_SWITCH = 3'd1,
        CMD_SLEEP  = 3'd2,
        CMD_WAIT   = 3'd3,
        CMD_SIGNAL = 3'd4,
        CMD_INIT   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEM,
        ST_SEARCH,
        ST_WAKE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        ALU_DEC_FLOOR,
        ALU_DEC_SAT,
        ALU_INC_SAT
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [VAL_W-1:0]  operand;
    } t_alu_req;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              negative;
        logic              nonpositive;
    } t_alu_rsp;

    function automatic logic [TID_W-1:0] ring_next(input logic [TID_W-1:0] t);
        return (t == TID_LAST) ? '0 : t + TID_W'(1);
    endfunction

endpackage

FILE: rtl/core/rrts_alu.sv
module rrts_alu (
    input  rrts_pkg::t_alu_req i_req,
    output rrts_pkg::t_alu_rsp o_rsp
);
    import rrts_pkg::*;

    logic [VAL_W-1:0] value;

    always_comb begin
        value = i_req.operand;
        case (i_req.op)
            ALU_DEC_FLOOR: begin
                if (i_req.operand != '0) value = i_req.operand - VAL_W'(1);
            end
            ALU_DEC_SAT: begin
                if (i_req.operand != VAL_SMIN) value = i_req.operand - VAL_W'(1);
            end
            ALU_INC_SAT: begin
                if (i_req.operand != VAL_SMAX) value = i_req.operand + VAL_W'(1);
            end
            default: begin
                value = i_req.operand;
            end
        endcase
    end

    assign o_rsp.value       = value;
    assign o_rsp.negative    = value[VAL_W-1];
    assign o_rsp.nonpositive = value[VAL_W-1] || (value == '0);

endmodule

FILE: rtl/core/round_robin_thread_scheduler.sv
// Round-robin thread scheduler with counting semaphores.
// Input channel: i_valid / o_ready carry one command transaction (command,
// semaphore index, sleep time, initial count). Output channel: o_valid / i_ready
// carry one result transaction per command (running thread, switch and block
// flags, woken thread, semaphore count).
// Commands are handled one at a time by a small sequencer around a single
// saturating add/subtract unit, which walks the thread ring one entry a cycle.
// Init and unused commands go straight to the output step; tick walks every
// thread's sleep counter; switch and sleep search the ring for a runnable
// thread; wait and signal update the semaphore, then may search or wake a thread.
// The next command can be accepted the cycle after the result is loaded into
// the output register, so the block takes no new command while one is still
// in progress.
// Reset (synchronous, active low) makes thread 0 current, clears all sleep
// counters, block tags and semaphore counts, and drops o_valid.
// If the receiver stalls, the result holds in the output register; the next
// command is still accepted and processed, then waits until the slot frees.
module round_robin_thread_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rrts_pkg::CMD_W-1:0]  i_command,
    input  logic [rrts_pkg::SEM_W-1:0]  i_semaphore_index,
    input  logic [rrts_pkg::VAL_W-1:0]  i_sleep_time,
    input  logic signed [rrts_pkg::VAL_W-1:0] i_initial_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rrts_pkg::TID_W-1:0]  o_running_thread,
    output logic                        o_switched,
    output logic                        o_none_runnable,
    output logic                        o_caller_blocked,
    output logic                        o_woken_valid,
    output logic [rrts_pkg::TID_W-1:0]  o_woken_thread,
    output logic signed [rrts_pkg::VAL_W-1:0] o_semaphore_count
);
    import rrts_pkg::*;

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [SEM_W-1:0]   r_sem, n_sem;
    logic [TID_W-1:0]   r_cur, n_cur;
    logic [TID_W-1:0]   r_idx, n_idx;
    logic [TID_W-1:0]   r_step, n_step;

    logic [BLK_W-1:0]   r_blocked [THREAD_COUNT];
    logic [BLK_W-1:0]   n_blocked [THREAD_COUNT];
    logic [VAL_W-1:0]   r_sleep [THREAD_COUNT];
    logic [VAL_W-1:0]   n_sleep [THREAD_COUNT];
    logic [VAL_W-1:0]   r_semc [SEMAPHORE_COUNT];
    logic [VAL_W-1:0]   n_semc [SEMAPHORE_COUNT];

    logic               r_sw, n_sw;
    logic               r_none, n_none;
    logic               r_blk, n_blk;
    logic               r_wv, n_wv;
    logic [TID_W-1:0]   r_woken, n_woken;
    logic [VAL_W-1:0]   r_count, n_count;

    logic               r_ovalid, n_ovalid;
    logic [TID_W-1:0]   r_orun, n_orun;
    logic               r_osw, n_osw;
    logic               r_onone, n_onone;
    logic               r_oblk, n_oblk;
    logic               r_owv, n_owv;
    logic [TID_W-1:0]   r_owoken, n_owoken;
    logic [VAL_W-1:0]   r_ocount, n_ocount;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic               accept;
    logic               sem_ok;
    logic [BLK_W-1:0]   sem_tag;

    rrts_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign sem_ok  = {1'b0, i_semaphore_index} < SEM_LIMIT;
    assign sem_tag = BLK_W'(r_sem) + BLK_W'(1);

    always_comb begin
        alu_req.operand = r_semc[r_sem];
        alu_req.op      = ALU_DEC_SAT;
        if (r_state == ST_TICK) begin
            alu_req.operand = r_sleep[r_idx];
            alu_req.op      = ALU_DEC_FLOOR;
        end else if (r_cmd == CMD_SIGNAL) begin
            alu_req.op      = ALU_INC_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
            for (int t = 0; t < THREAD_COUNT; t++) begin
                r_blocked[t] <= '0;
                r_sleep[t]   <= '0;
            end
            for (int s = 0; s < SEMAPHORE_COUNT; s++) begin
                r_semc[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_ovalid <= n_ovalid;
            r_blocked <= n_blocked;
            r_sleep   <= n_sleep;
            r_semc    <= n_semc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sem    <= n_sem;
        r_idx    <= n_idx;
        r_step   <= n_step;
        r_sw     <= n_sw;
        r_none   <= n_none;
        r_blk    <= n_blk;
        r_wv     <= n_wv;
        r_woken  <= n_woken;
        r_count  <= n_count;
        r_orun   <= n_orun;
        r_osw    <= n_osw;
        r_onone  <= n_onone;
        r_oblk   <= n_oblk;
        r_owv    <= n_owv;
        r_owoken <= n_owoken;
        r_ocount <= n_ocount;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_sem     = r_sem;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_step    = r_step;
        n_blocked = r_blocked;
        n_sleep   = r_sleep;
        n_semc    = r_semc;
        n_sw      = r_sw;
        n_none    = r_none;
        n_blk     = r_blk;
        n_wv      = r_wv;
        n_woken   = r_woken;
        n_count   = r_count;
        n_ovalid  = r_ovalid && !i_ready;
        n_orun    = r_orun;
        n_osw     = r_osw;
        n_onone   = r_onone;
        n_oblk    = r_oblk;
        n_owv     = r_owv;
        n_owoken  = r_owoken;
        n_ocount  = r_ocount;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_command;
                    n_sem   = i_semaphore_index;
                    n_sw    = 1'b0;
                    n_none  = 1'b0;
                    n_blk   = 1'b0;
                    n_wv    = 1'b0;
                    n_woken = '0;
                    n_count = '0;
                    n_idx   = ring_next(r_cur);
                    n_step  = '0;
                    n_state = ST_OUT;
                    unique case (i_command) inside
                        CMD_TICK: begin
                            n_idx   = '0;
                            n_state = ST_TICK;
                        end
                        CMD_SWITCH: begin
                            n_state = ST_SEARCH;
                        end
                        CMD_SLEEP: begin
                            n_sleep[r_cur] = i_sleep_time;
                            n_state        = ST_SEARCH;
                        end
                        CMD_WAIT, CMD_SIGNAL: begin
                            if (sem_ok) n_state = ST_SEM;
                        end
                        CMD_INIT: begin
                            if (sem_ok) begin
                                n_semc[i_semaphore_index] = i_initial_count;
                                n_count                   = i_initial_count;
                            end
                        end
                        default: begin
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                n_sleep[r_idx] = alu_rsp.value;
                if (r_idx == TID_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + TID_W'(1);
                end
            end
            ST_SEM: begin
                n_semc[r_sem] = alu_rsp.value;
                n_count       = alu_rsp.value;
                n_state       = ST_OUT;
                if (r_cmd == CMD_WAIT) begin
                    if (alu_rsp.negative) begin
                        n_blocked[r_cur] = sem_tag;
                        n_blk            = 1'b1;
                        n_state          = ST_SEARCH;
                    end
                end else if (alu_rsp.nonpositive) begin
                    n_state = ST_WAKE;
                end
            end
            ST_SEARCH: begin
                if (r_blocked[r_idx] == '0 && r_sleep[r_idx] == '0) begin
                    n_cur   = r_idx;
                    n_sw    = 1'b1;
                    n_state = ST_OUT;
                end else if (r_step == TID_LAST) begin
                    n_none  = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_idx  = ring_next(r_idx);
                    n_step = r_step + TID_W'(1);
                end
            end
            ST_WAKE: begin
                if (r_blocked[r_idx] == sem_tag) begin
                    n_blocked[r_idx] = '0;
                    n_wv             = 1'b1;
                    n_woken          = r_idx;
                    n_state          = ST_OUT;
                end else if (r_step == TID_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx  = ring_next(r_idx);
                    n_step = r_step + TID_W'(1);
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_orun   = r_cur;
                    n_osw    = r_sw;
                    n_onone  = r_none;
                    n_oblk   = r_blk;
                    n_owv    = r_wv;
                    n_owoken = r_woken;
                    n_ocount = r_count;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_running_thread  = r_orun;
    assign o_switched        = r_osw;
    assign o_none_runnable   = r_onone;
    assign o_caller_blocked  = r_oblk;
    assign o_woken_valid     = r_owv;
    assign o_woken_thread    = r_owoken;
    assign o_semaphore_count = r_ocount;

endmodule

FILE: rtl/core/rrts_checker.sv
`include "assert_macros.svh"

module rrts_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [rrts_pkg::TID_W-1:0]  o_running_thread,
    input  logic                        o_switched,
    input  logic                        o_none_runnable,
    input  logic                        o_caller_blocked,
    input  logic [rrts_pkg::TID_W-1:0]  o_woken_thread,
    input  logic signed [rrts_pkg::VAL_W-1:0] o_semaphore_count
);
    import rrts_pkg::*;

    `ASSERT_STD(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready, "ready after accept")
    `ASSERT_STD(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_running_thread) && $stable(o_semaphore_count)), "stalled result changed")
    `ASSERT_STD(a_switch_excl, o_valid |-> !(o_switched && o_none_runnable), "switched and none runnable")
    `ASSERT_STD(a_blocked_search, (o_valid && o_caller_blocked) |-> (o_switched || o_none_runnable), "blocked without search")
    `ASSERT_STD(a_thread_range, o_valid |-> ((o_running_thread <= TID_LAST) && (o_woken_thread <= TID_LAST)), "thread index out of range")

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);
